/* rtl/core/afinv_pkg.sv */
// Shared types, constants and helpers for the affine matrix inverse block.
package afinv_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int VAL_W         = 32;            // Q16.16 field width
  localparam int DET_W         = 2 * VAL_W;     // determinant magnitude width
  localparam int QUO_W         = 33;            // quotient bits kept before overflow
  localparam int MIN_W         = 33;            // threshold register width
  localparam int LANES         = 4;             // a', b', c', d'
  localparam logic [MIN_W-1:0] MIN_DET_RST = 33'd4295;

  // Lane order of the linear inverse.
  localparam int LN_A = 0;
  localparam int LN_B = 1;
  localparam int LN_C = 2;
  localparam int LN_D = 3;

  // Per-item data that rides along with the divider lanes.
  typedef struct packed {
    logic [DET_W-1:0] dmag;
    logic             dneg;
    logic             inv;
    logic [LANES-1:0] lsgn;
    logic [VAL_W-1:0] tx;
    logic [VAL_W-1:0] ty;
  } side_t;

  // One restoring divider lane.
  typedef struct packed {
    logic [DET_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [QUO_W-1:0] nlo;
    logic             ovf;
  } lane_t;

  // Sign/magnitude to saturated two's complement; result is {sat, value}.
  function automatic logic [VAL_W:0] clamp_pack(input logic neg,
                                                input logic [DET_W+1:0] mag);
    logic [VAL_W-1:0] val;
    logic             sat;
    begin
      sat = 1'b0;
      if (neg) begin
        if (mag > (DET_W+2)'(64'h8000_0000)) begin
          val = 32'h8000_0000;
          sat = 1'b1;
        end else begin
          val = 32'd0 - mag[VAL_W-1:0];
        end
      end else begin
        if (mag > (DET_W+2)'(64'h7FFF_FFFF)) begin
          val = 32'h7FFF_FFFF;
          sat = 1'b1;
        end else begin
          val = mag[VAL_W-1:0];
        end
      end
      clamp_pack = {sat, val};
    end
  endfunction

endpackage

/* rtl/core/affine_matrix_inverse_unit.sv */
// Pipelined inverse of a 2D affine matrix in signed fixed point.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | in_tdata: a, b, c, d, tx, ty (32 b each)
//  out_    | out | out_tvalid/out_tready| out_tdata: a', b', c', d', tx', ty'; out_tuser
//  cfg_    | in  | cfg_wr_en            | cfg_wr_data: min |det| (Q1.32)
//
// One request per cycle while the skid register is empty; 41 register stages. 34 of them
// are the restoring dividers (a load stage plus 33 stages of one quotient bit each, four
// lanes side by side).
// Reset clears every valid bit, output and skid included, and loads the threshold with
// its default; data registers are not reset.
// All stages before the output register share one enable that drops only while
// the skid register is full, so in_tready comes from a flop and never from out_tready.
module affine_matrix_inverse_unit #(
  parameter int FRAC_BITS = afinv_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [191:0]  in_tdata,   // a, b, c, d, tx, ty from bit 0 up
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [191:0]  out_tdata,  // a', b', c', d', tx', ty' from bit 0 up
  output logic [1:0]    out_tuser,  // invertible, saturated from bit 0 up
  input  logic          cfg_wr_en,
  input  logic [32:0]   cfg_wr_data
);

  localparam int VW  = afinv_pkg::VAL_W;
  localparam int DW  = afinv_pkg::DET_W;
  localparam int QW  = afinv_pkg::QUO_W;
  localparam int NL  = afinv_pkg::LANES;
  localparam int SH2 = 2 * FRAC_BITS;
  // numerator: m << 2F plus half the divisor
  localparam int NW  = ((SH2 + VW > DW - 1) ? (SH2 + VW) : (DW - 1)) + 1;
  localparam int DS  = QW;            // divider steps

  // threshold register
  logic [afinv_pkg::MIN_W-1:0] min_det_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_det_r <= afinv_pkg::MIN_DET_RST;
    end else if (cfg_wr_en) begin
      min_det_r <= cfg_wr_data;
    end
  end

  // global advance: held only while the skid register holds a result
  logic skid_v_r;
  logic en;
  assign en        = ~skid_v_r;
  assign in_tready = en;

  // ---------------- stage 1: products for the determinant, magnitudes
  logic                 v1_r;
  logic signed [DW-1:0] s1_ad_r, s1_bc_r;
  logic [VW-1:0]        s1_m_r [NL];
  logic [NL-1:0]        s1_sg_r;
  logic [VW-1:0]        s1_tx_r, s1_ty_r;

  logic signed [VW-1:0] ia, ib, ic, id;
  assign ia = in_tdata[31:0];
  assign ib = in_tdata[63:32];
  assign ic = in_tdata[95:64];
  assign id = in_tdata[127:96];

  function automatic logic [VW-1:0] mag32(input logic signed [VW-1:0] x);
    mag32 = x[VW-1] ? (32'd0 - x) : x;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ad_r <= ia * id;
      s1_bc_r <= ib * ic;
      // lane numerators: a' <- d, b' <- -b, c' <- -c, d' <- a
      s1_m_r[afinv_pkg::LN_A] <= mag32(id);
      s1_m_r[afinv_pkg::LN_B] <= mag32(ib);
      s1_m_r[afinv_pkg::LN_C] <= mag32(ic);
      s1_m_r[afinv_pkg::LN_D] <= mag32(ia);
      s1_sg_r[afinv_pkg::LN_A] <= id[VW-1];
      s1_sg_r[afinv_pkg::LN_B] <= ~ib[VW-1];
      s1_sg_r[afinv_pkg::LN_C] <= ~ic[VW-1];
      s1_sg_r[afinv_pkg::LN_D] <= ia[VW-1];
      s1_tx_r <= in_tdata[159:128];
      s1_ty_r <= in_tdata[191:160];
    end
  end

  // ---------------- stage 2: determinant
  logic                 v2_r;
  logic signed [DW:0]   s2_det_r;
  logic [VW-1:0]        s2_m_r [NL];
  logic [NL-1:0]        s2_sg_r;
  logic [VW-1:0]        s2_tx_r, s2_ty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_det_r <= (DW+1)'(s1_ad_r) - (DW+1)'(s1_bc_r);
      s2_m_r   <= s1_m_r;
      s2_sg_r  <= s1_sg_r;
      s2_tx_r  <= s1_tx_r;
      s2_ty_r  <= s1_ty_r;
    end
  end

  // ---------------- stage 3: |det|, threshold, numerators
  logic          v3_r;
  logic [DW-1:0] s3_dmag_r;
  logic          s3_dneg_r, s3_inv_r;
  logic [NW-1:0] s3_n_r [NL];
  logic [NL-1:0] s3_sg_r;
  logic [VW-1:0] s3_tx_r, s3_ty_r;

  logic [DW-1:0] dmag_c;
  assign dmag_c = s2_det_r[DW] ? DW'(-s2_det_r) : s2_det_r[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_dmag_r <= dmag_c;
      s3_dneg_r <= s2_det_r[DW];
      s3_inv_r  <= (dmag_c != '0) && (dmag_c >= DW'(min_det_r));
      for (int k = 0; k < NL; k++) begin
        s3_n_r[k] <= (NW'(s2_m_r[k]) << SH2) + NW'(dmag_c >> 1);
      end
      s3_sg_r <= s2_sg_r;
      s3_tx_r <= s2_tx_r;
      s3_ty_r <= s2_ty_r;
    end
  end

  // ---------------- stage 4 .. 4+DS: restoring dividers, one bit per stage
  logic                 dv_v_r    [DS+1];
  afinv_pkg::side_t     dv_side_r [DS+1];
  afinv_pkg::lane_t     dv_lane_r [DS+1][NL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side_r[0].dmag <= s3_dmag_r;
      dv_side_r[0].dneg <= s3_dneg_r;
      dv_side_r[0].inv  <= s3_inv_r;
      dv_side_r[0].lsgn <= s3_sg_r;
      dv_side_r[0].tx   <= s3_tx_r;
      dv_side_r[0].ty   <= s3_ty_r;
      for (int k = 0; k < NL; k++) begin
        // quotient of 2^QW or more always saturates
        dv_lane_r[0][k].ovf <= DW'(s3_n_r[k] >> QW) >= s3_dmag_r;
        dv_lane_r[0][k].rem <= DW'(s3_n_r[k] >> QW);
        dv_lane_r[0][k].nlo <= s3_n_r[k][QW-1:0];
        dv_lane_r[0][k].quo <= '0;
      end
    end
  end

  for (genvar j = 0; j < DS; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    for (genvar k = 0; k < NL; k++) begin : g_lane
      logic [DW:0] trial;
      logic        ge;
      assign trial = {dv_lane_r[j][k].rem, dv_lane_r[j][k].nlo[QW-1]};
      assign ge    = trial >= {1'b0, dv_side_r[j].dmag};

      always_ff @(posedge clk) begin
        if (en) begin
          dv_lane_r[j+1][k].rem <= ge ? DW'(trial - {1'b0, dv_side_r[j].dmag})
                                      : trial[DW-1:0];
          dv_lane_r[j+1][k].quo <= {dv_lane_r[j][k].quo[QW-2:0], ge};
          dv_lane_r[j+1][k].nlo <= {dv_lane_r[j][k].nlo[QW-2:0], 1'b0};
          dv_lane_r[j+1][k].ovf <= dv_lane_r[j][k].ovf;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_side_r[j+1] <= dv_side_r[j];
      end
    end
  end

  // ---------------- stage 5: clamp the linear inverse
  logic          v5_r;
  logic [VW-1:0] s5_lin_r [NL];
  logic          s5_sat_r, s5_inv_r;
  logic [VW-1:0] s5_tx_r, s5_ty_r;

  logic [VW:0]   lin_c [NL];
  logic [NL-1:0] lin_sat;
  always_comb begin
    for (int k = 0; k < NL; k++) begin
      lin_c[k] = afinv_pkg::clamp_pack(
          dv_side_r[DS].lsgn[k] ^ dv_side_r[DS].dneg,
          dv_lane_r[DS][k].ovf ? (DW+2)'(1) << QW : (DW+2)'(dv_lane_r[DS][k].quo));
      lin_sat[k] = lin_c[k][VW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= dv_v_r[DS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NL; k++) begin
        s5_lin_r[k] <= lin_c[k][VW-1:0];
      end
      s5_sat_r <= |lin_sat;
      s5_inv_r <= dv_side_r[DS].inv;
      s5_tx_r  <= dv_side_r[DS].tx;
      s5_ty_r  <= dv_side_r[DS].ty;
    end
  end

  // ---------------- stage 6: translation products
  logic                 v6_r;
  logic signed [DW-1:0] s6_p_r [4];
  logic [VW-1:0]        s6_lin_r [NL];
  logic                 s6_sat_r, s6_inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_p_r[0] <= $signed(s5_tx_r) * $signed(s5_lin_r[afinv_pkg::LN_A]);
      s6_p_r[1] <= $signed(s5_ty_r) * $signed(s5_lin_r[afinv_pkg::LN_C]);
      s6_p_r[2] <= $signed(s5_tx_r) * $signed(s5_lin_r[afinv_pkg::LN_B]);
      s6_p_r[3] <= $signed(s5_ty_r) * $signed(s5_lin_r[afinv_pkg::LN_D]);
      s6_lin_r  <= s5_lin_r;
      s6_sat_r  <= s5_sat_r;
      s6_inv_r  <= s5_inv_r;
    end
  end

  // ---------------- stage 7: negated dot products
  logic                 v7_r;
  logic signed [DW+1:0] s7_t_r [2];
  logic [VW-1:0]        s7_lin_r [NL];
  logic                 s7_sat_r, s7_inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_t_r[0] <= -((DW+2)'(s6_p_r[0]) + (DW+2)'(s6_p_r[1]));
      s7_t_r[1] <= -((DW+2)'(s6_p_r[2]) + (DW+2)'(s6_p_r[3]));
      s7_lin_r  <= s6_lin_r;
      s7_sat_r  <= s6_sat_r;
      s7_inv_r  <= s6_inv_r;
    end
  end

  // ---------------- final: round half away from zero, clamp, zero if singular
  logic [DW+1:0] tmag [2];
  logic [VW:0]   tr_c [2];
  logic [191:0]  res_data;
  logic [1:0]    res_user;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      tmag[k] = s7_t_r[k][DW+1] ? (DW+2)'(-s7_t_r[k]) : s7_t_r[k];
      tmag[k] = (tmag[k] + ((DW+2)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      tr_c[k] = afinv_pkg::clamp_pack(s7_t_r[k][DW+1], tmag[k]);
    end
    if (s7_inv_r) begin
      res_data = {tr_c[1][VW-1:0], tr_c[0][VW-1:0],
                  s7_lin_r[afinv_pkg::LN_D], s7_lin_r[afinv_pkg::LN_C],
                  s7_lin_r[afinv_pkg::LN_B], s7_lin_r[afinv_pkg::LN_A]};
      res_user = {s7_sat_r | tr_c[0][VW] | tr_c[1][VW], 1'b1};
    end else begin
      res_data = '0;
      res_user = '0;
    end
  end

  // ---------------- output register plus skid register
  logic         out_v_r;
  logic [191:0] out_data_r, skid_data_r;
  logic [1:0]   out_user_r, skid_user_r;
  logic         out_take;

  assign out_take = out_v_r & out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || out_take) begin
      out_v_r <= v7_r;
    end else if (v7_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_tready) begin
        out_data_r <= skid_data_r;
        out_user_r <= skid_user_r;
      end
    end else if (!out_v_r || out_take) begin
      out_data_r <= res_data;
      out_user_r <= res_user;
    end else begin
      skid_data_r <= res_data;
      skid_user_r <= res_user;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // ---------------- checks
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
      skid_v_r |-> out_v_r)
    else $error("skid register holds a request with the output empty");

  a_singular_zero : assert property (@(posedge clk) disable iff (!rst_n)
      (out_v_r && !out_user_r[0]) |-> (out_data_r == '0 && !out_user_r[1]))
    else $error("non-invertible result carries nonzero data");

  a_park_in_skid : assert property (@(posedge clk) disable iff (!rst_n)
      (v7_r && !skid_v_r && out_v_r && !out_tready) |=> skid_v_r)
    else $error("blocked request was not parked in the skid register");

  a_stall_holds_tail : assert property (@(posedge clk) disable iff (!rst_n)
      skid_v_r |=> (v7_r == $past(v7_r)))
    else $error("pipeline moved while the skid register was full");

endmodule
